>>> design/bcpe_pkg.sv
// Shared types and constants for the cubic Bezier point evaluator.
// Used by the weight pipeline, the blend pipeline and the top level.
// No dependencies.
package bcpe_pkg;

  // Width of the configuration register index.
  localparam int CFG_INDEX_WIDTH = 3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_POINT_ZERO  = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_POINT_ONE   = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_POINT_TWO   = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_POINT_THREE = 3'd3;

  // Load enables of the five pipeline stages.
  typedef struct packed {
    logic s1;  // clamp of t, forming 1-t
    logic s2;  // squares of t and 1-t
    logic s3;  // Bernstein weights
    logic s4;  // weight times coordinate
    logic s5;  // sum, round, output register
  } stage_en_t;

endpackage

>>> design/cubic_bezier_point_eval.sv
// Top level of the cubic Bezier point evaluator.
// Depends on bcpe_pkg, bcpe_weights and bcpe_blend.
//
// Usage:
//   The four control points are written through cfg_we, cfg_index and
//   cfg_data while the block is idle; each packs signed x, y and z.
//   Indexes beyond the last point are ignored.
//   Parameter values t arrive on the s_ stream, one item per handshake,
//   as signed fixed point with T_FRAC_BITS fraction bits; t is clamped
//   to the range zero to one. Each item gives one curve point on the m_
//   stream.
//   m_tvalid rises once an accepted item has passed all register stages,
//   in order: clamp, squares, weights, products and rounded sum each take
//   one register stage.
//   One item is accepted in every cycle while the receiver takes results.
//   When the receiver stalls, the result is held in the output register
//   and the stages behind it keep filling until every stage holds an item;
//   only then is s_tready dropped. Nothing is lost or repeated.
//   Reset clears the valid bits of all stages and the control points.
module cubic_bezier_point_eval
  import bcpe_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  parameter int T_FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0]        cfg_index,
  input  logic [3*COORD_WIDTH-1:0]          cfg_data,
  // Input stream.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [((T_FRAC_BITS+9)/8)*8-1:0]  s_tdata,  // t_param
  // Output stream.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_tdata  // x_out, y_out, z_out
);

  localparam int CW   = COORD_WIDTH;
  localparam int WW   = 3 * T_FRAC_BITS + 1;
  localparam int OUTW = ((3 * COORD_WIDTH + 7) / 8) * 8;

  logic [3*CW-1:0]   point_zero;
  logic [3*CW-1:0]   point_one;
  logic [3*CW-1:0]   point_two;
  logic [3*CW-1:0]   point_three;
  logic [5:1]        valid;
  stage_en_t         en;
  logic [WW-1:0]     w0;
  logic [WW-1:0]     w1;
  logic [WW-1:0]     w2;
  logic [WW-1:0]     w3;
  logic signed [CW-1:0] coord [3];

  // Control point registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      point_zero  <= '0;
      point_one   <= '0;
      point_two   <= '0;
      point_three <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POINT_ZERO:  point_zero  <= cfg_data;
        CFG_POINT_ONE:   point_one   <= cfg_data;
        CFG_POINT_TWO:   point_two   <= cfg_data;
        CFG_POINT_THREE: point_three <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or when the stage after it moves on.
  assign en.s5    = !valid[5] || m_tready;
  assign en.s4    = !valid[4] || en.s5;
  assign en.s3    = !valid[3] || en.s4;
  assign en.s2    = !valid[2] || en.s3;
  assign en.s1    = !valid[1] || en.s2;
  assign s_tready = en.s1;

  // Valid bits travelling with the items.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en.s1) valid[1] <= s_tvalid;
      if (en.s2) valid[2] <= valid[1];
      if (en.s3) valid[3] <= valid[2];
      if (en.s4) valid[4] <= valid[3];
      if (en.s5) valid[5] <= valid[4];
    end
  end

  // Shared weight pipeline.
  bcpe_weights #(
    .T_FRAC_BITS(T_FRAC_BITS)
  ) u_weights (
    .clk     (clk),
    .en      (en),
    .t_param (s_tdata[T_FRAC_BITS+1:0]),
    .w0      (w0),
    .w1      (w1),
    .w2      (w2),
    .w3      (w3)
  );

  // One blend lane for each of x, y and z.
  for (genvar k = 0; k < 3; k++) begin : g_lane
    bcpe_blend #(
      .COORD_WIDTH(COORD_WIDTH),
      .T_FRAC_BITS(T_FRAC_BITS)
    ) u_blend (
      .clk   (clk),
      .en    (en),
      .w0    (w0),
      .w1    (w1),
      .w2    (w2),
      .w3    (w3),
      .c0    (point_zero[k*CW +: CW]),
      .c1    (point_one[k*CW +: CW]),
      .c2    (point_two[k*CW +: CW]),
      .c3    (point_three[k*CW +: CW]),
      .coord (coord[k])
    );
  end

  // Output stream.
  assign m_tvalid = valid[5];
  assign m_tdata  = OUTW'({coord[2], coord[1], coord[0]});

endmodule

>>> design/bcpe_weights.sv
// Weight pipeline: clamps t and forms the four Bernstein weights exactly.
// Three register stages, loaded by the enables in stage_en_t.
// Depends on bcpe_pkg.
module bcpe_weights
  import bcpe_pkg::*;
#(
  parameter int T_FRAC_BITS = 16
) (
  input  logic                      clk,
  input  stage_en_t                 en,
  input  logic signed [T_FRAC_BITS+1:0] t_param,
  output logic [3*T_FRAC_BITS:0]    w0,
  output logic [3*T_FRAC_BITS:0]    w1,
  output logic [3*T_FRAC_BITS:0]    w2,
  output logic [3*T_FRAC_BITS:0]    w3
);

  localparam int TW = T_FRAC_BITS + 1;      // width of clamped t and 1-t
  localparam int SW = 2 * T_FRAC_BITS + 1;  // width of the squares
  localparam int WW = 3 * T_FRAC_BITS + 1;  // width of a weight
  localparam int PW = SW + TW;              // width of a square times t
  localparam logic [TW-1:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

  logic [TW-1:0]   t_clamped;
  logic [TW-1:0]   t1;
  logic [TW-1:0]   u1;
  logic [2*TW-1:0] uu_full;
  logic [2*TW-1:0] tt_full;
  logic [SW-1:0]   uu2;
  logic [SW-1:0]   tt2;
  logic [TW-1:0]   t2;
  logic [TW-1:0]   u2;
  logic [PW-1:0]   uuu_full;
  logic [PW-1:0]   uut_full;
  logic [PW-1:0]   ttu_full;
  logic [PW-1:0]   ttt_full;
  logic [PW+1:0]   uut_x3;
  logic [PW+1:0]   ttu_x3;

  // Clamp t to the range zero to one.
  always_comb begin
    if (t_param[T_FRAC_BITS+1]) begin
      t_clamped = '0;
    end else if (t_param[T_FRAC_BITS] && (t_param[T_FRAC_BITS-1:0] != '0)) begin
      t_clamped = T_ONE;
    end else begin
      t_clamped = t_param[TW-1:0];
    end
  end

  // Stage one: clamped t and its complement.
  always_ff @(posedge clk) begin
    if (en.s1) begin
      t1 <= t_clamped;
      u1 <= T_ONE - t_clamped;
    end
  end

  // Stage two: squares. Both are at most one, so the top bit is never set.
  assign uu_full = u1 * u1;
  assign tt_full = t1 * t1;

  always_ff @(posedge clk) begin
    if (en.s2) begin
      uu2 <= uu_full[SW-1:0];
      tt2 <= tt_full[SW-1:0];
      t2  <= t1;
      u2  <= u1;
    end
  end

  // Stage three: cubes and the two middle weights with their factor of three.
  assign uuu_full = uu2 * u2;
  assign uut_full = uu2 * t2;
  assign ttu_full = tt2 * u2;
  assign ttt_full = tt2 * t2;
  assign uut_x3   = {2'b00, uut_full} + {1'b0, uut_full, 1'b0};
  assign ttu_x3   = {2'b00, ttu_full} + {1'b0, ttu_full, 1'b0};

  always_ff @(posedge clk) begin
    if (en.s3) begin
      w0 <= uuu_full[WW-1:0];
      w1 <= uut_x3[WW-1:0];
      w2 <= ttu_x3[WW-1:0];
      w3 <= ttt_full[WW-1:0];
    end
  end

endmodule

>>> design/bcpe_blend.sv
// Blend pipeline for one coordinate: weighted sum of four control values,
// rounded to nearest. Two register stages. Depends on bcpe_pkg.
module bcpe_blend
  import bcpe_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  parameter int T_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  stage_en_t                     en,
  input  logic [3*T_FRAC_BITS:0]        w0,
  input  logic [3*T_FRAC_BITS:0]        w1,
  input  logic [3*T_FRAC_BITS:0]        w2,
  input  logic [3*T_FRAC_BITS:0]        w3,
  input  logic signed [COORD_WIDTH-1:0] c0,
  input  logic signed [COORD_WIDTH-1:0] c1,
  input  logic signed [COORD_WIDTH-1:0] c2,
  input  logic signed [COORD_WIDTH-1:0] c3,
  output logic signed [COORD_WIDTH-1:0] coord
);

  localparam int SHIFT = 3 * T_FRAC_BITS;
  localparam int PW    = SHIFT + 2 + COORD_WIDTH;  // signed product width
  localparam int AW    = PW + 2;                   // accumulator width
  localparam logic [AW-1:0] ROUND_BIT = {{(AW-1){1'b0}}, 1'b1} << (SHIFT - 1);

  logic signed [PW-1:0] p0;
  logic signed [PW-1:0] p1;
  logic signed [PW-1:0] p2;
  logic signed [PW-1:0] p3;
  logic signed [AW-1:0] acc;

  // Stage four: each weight times its control coordinate.
  always_ff @(posedge clk) begin
    if (en.s4) begin
      p0 <= $signed({1'b0, w0}) * c0;
      p1 <= $signed({1'b0, w1}) * c1;
      p2 <= $signed({1'b0, w2}) * c2;
      p3 <= $signed({1'b0, w3}) * c3;
    end
  end

  // Sum with the half-unit added; the weights sum to one, so the result fits.
  assign acc = AW'(p0) + AW'(p1) + AW'(p2) + AW'(p3) + $signed(ROUND_BIT);

  // Stage five: drop the fraction bits.
  always_ff @(posedge clk) begin
    if (en.s5) begin
      coord <= acc[SHIFT +: COORD_WIDTH];
    end
  end

endmodule

>>> design/bcpe_checker.sv
// Port-level checker for the cubic Bezier point evaluator, with its bind.
// Depends on bcpe_pkg and on cubic_bezier_point_eval.
module bcpe_checker
  import bcpe_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  parameter int T_FRAC_BITS = 16
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               cfg_we,
  input logic [CFG_INDEX_WIDTH-1:0]         cfg_index,
  input logic [3*COORD_WIDTH-1:0]           cfg_data,
  input logic                               s_tvalid,
  input logic                               s_tready,
  input logic [((T_FRAC_BITS+9)/8)*8-1:0]   s_tdata,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_tdata
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result shown after reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // With no result waiting, the pipeline can always take an item.
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // Without receiver stalls, an accepted item reaches the output through the pipeline stages.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready
    |=> m_tvalid)
    else $error("accepted item did not arrive");

endmodule

bind cubic_bezier_point_eval bcpe_checker #(
  .COORD_WIDTH(COORD_WIDTH),
  .T_FRAC_BITS(T_FRAC_BITS)
) u_bcpe_checker (.*);

>>> sim/cubic_bezier_point_eval_checker.sv
// Checker for the cubic Bezier point evaluator: watches the configuration port and both
// streams, predicts every curve point and compares it field by field with the block's output.
// Depends on bcpe_pkg for the register index width and names.
module cubic_bezier_point_eval_checker
  import bcpe_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  parameter int T_FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0]          cfg_index,
  input  logic [3*COORD_WIDTH-1:0]            cfg_data,
  input  logic                                s_tvalid,
  input  logic                                s_tready,
  input  logic [((T_FRAC_BITS+9)/8)*8-1:0]    s_tdata,  // t_param
  input  logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]  m_tdata,  // x_out, y_out, z_out
  output int                                  fault_count,
  output int                                  pending_count,
  output int                                  checked_count
);

  localparam int T_WIDTH = T_FRAC_BITS + 2;
  localparam int WEIGHT_SHIFT = 3 * T_FRAC_BITS;
  localparam int ACC_WIDTH = WEIGHT_SHIFT + COORD_WIDTH + 4;
  localparam int REPORT_LIMIT = 100;
  localparam logic [COORD_WIDTH-1:0] COORD_BIAS = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam logic [ACC_WIDTH-1:0] T_UNIT = ACC_WIDTH'(1) << T_FRAC_BITS;
  localparam logic [ACC_WIDTH-1:0] HALF_LSB = ACC_WIDTH'(1) << (WEIGHT_SHIFT - 1);

  // One curve point, laid out as on m_tdata with x in the lowest bits.
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] z;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] x;
  } curve_point_t;

  logic [3*COORD_WIDTH-1:0] control_point [4];
  curve_point_t expected_points [$];

  // Curve point at one parameter value: clamp t, form the four Bernstein weights
  // exactly, blend offset-binary coordinates and round halves upwards.
  function automatic curve_point_t eval_curve(input logic [T_WIDTH-1:0] t_raw);
    logic [ACC_WIDTH-1:0] t;
    logic [ACC_WIDTH-1:0] u;
    logic [ACC_WIDTH-1:0] acc;
    logic [ACC_WIDTH-1:0] weight [4];
    logic [COORD_WIDTH-1:0] coord [3];
    if (t_raw[T_WIDTH-1]) begin
      t = '0;
    end else if (t_raw > T_UNIT) begin
      t = T_UNIT;
    end else begin
      t = t_raw;
    end
    u = T_UNIT - t;
    weight[0] = u * u * u;
    weight[1] = 3 * u * u * t;
    weight[2] = 3 * u * t * t;
    weight[3] = t * t * t;
    for (int k = 0; k < 3; k++) begin
      acc = HALF_LSB;
      for (int i = 0; i < 4; i++) begin
        acc += weight[i] *
               ACC_WIDTH'(control_point[i][k*COORD_WIDTH +: COORD_WIDTH] ^ COORD_BIAS);
      end
      coord[k] = acc[WEIGHT_SHIFT +: COORD_WIDTH] ^ COORD_BIAS;
    end
    return '{z: coord[2], y: coord[1], x: coord[0]};
  endfunction

  // Prints one line for a mismatch (up to a limit) and counts it.
  task automatic report_mismatch(input string what, input longint want, input longint seen);
    if (fault_count < REPORT_LIMIT) begin
      $display("%0t: %s: expected %0d, got %0d", $time, what, want, seen);
    end
    fault_count++;
  endtask

  // Track the control points, queue a prediction per accepted item and
  // compare each accepted curve point with the oldest prediction.
  always @(posedge clk) begin
    curve_point_t want;
    curve_point_t seen;
    if (rst) begin
      expected_points.delete();
      foreach (control_point[i]) begin
        control_point[i] = '0;
      end
    end else begin
      if (s_tvalid && s_tready) begin
        expected_points.push_back(eval_curve(s_tdata[T_WIDTH-1:0]));
      end
      if (m_tvalid && m_tready) begin
        seen = m_tdata[3*COORD_WIDTH-1:0];
        if (expected_points.size() == 0) begin
          report_mismatch("curve point with no parameter value waiting, x_out", 0, seen.x);
        end else begin
          want = expected_points.pop_front();
          if (seen.x !== want.x) report_mismatch("x_out", want.x, seen.x);
          if (seen.y !== want.y) report_mismatch("y_out", want.y, seen.y);
          if (seen.z !== want.z) report_mismatch("z_out", want.z, seen.z);
          checked_count++;
        end
      end
      // Writes beyond the last control point are dropped by the block.
      if (cfg_we && cfg_index <= CFG_POINT_THREE) begin
        control_point[cfg_index] = cfg_data;
      end
    end
    pending_count <= expected_points.size();
  end

endmodule

>>> sim/cubic_bezier_point_eval_test.sv
// Testbench top for the cubic Bezier point evaluator: drives control points and
// parameter values with random idling on both sides, and gives the verdict.
// Depends on bcpe_pkg, cubic_bezier_point_eval and cubic_bezier_point_eval_checker.
module cubic_bezier_point_eval_test;
  import bcpe_pkg::*;

  localparam int COORD_WIDTH = 16;
  localparam int T_FRAC_BITS = 16;
  localparam int T_WIDTH = T_FRAC_BITS + 2;
  localparam int S_WIDTH = ((T_FRAC_BITS + 9) / 8) * 8;
  localparam int M_WIDTH = ((3 * COORD_WIDTH + 7) / 8) * 8;
  localparam int P_WIDTH = 3 * COORD_WIDTH;

  localparam logic [T_WIDTH-1:0] T_UNIT = T_WIDTH'(1) << T_FRAC_BITS;
  localparam logic [T_WIDTH-1:0] T_ONE_LSB = T_WIDTH'(1);
  localparam logic [T_WIDTH-1:0] T_HALF = T_UNIT >> 1;
  localparam logic [T_WIDTH-1:0] T_MOST = {1'b0, {(T_WIDTH-1){1'b1}}};
  localparam logic [T_WIDTH-1:0] T_LEAST = {1'b1, {(T_WIDTH-1){1'b0}}};
  localparam logic [T_WIDTH-1:0] T_MINUS_LSB = '1;
  localparam logic [T_WIDTH-1:0] T_CORNERS [11] = '{
    '0, T_ONE_LSB, T_HALF >> 1, T_HALF, T_HALF + (T_HALF >> 1), T_UNIT - T_ONE_LSB, T_UNIT,
    T_UNIT + T_ONE_LSB, T_MOST, T_LEAST, T_MINUS_LSB
  };

  localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS = 130;
  localparam int BURST_ITEMS = 40;
  localparam int LONG_HOLD = 80;
  localparam int SETTLE = 8;
  localparam int DRAIN = 20;
  localparam longint TIME_LIMIT = 5_000_000;

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         cfg_we;
  logic [CFG_INDEX_WIDTH-1:0]   cfg_index;
  logic [P_WIDTH-1:0]           cfg_data;
  logic                         s_tvalid;
  logic                         s_tready;
  logic [S_WIDTH-1:0]           s_tdata;  // t_param
  logic                         m_tvalid;
  logic                         m_tready;
  logic [M_WIDTH-1:0]           m_tdata;  // x_out, y_out, z_out

  int fault_count;
  int pending_count;
  int checked_count;
  int items_sent = 0;
  int settings_loaded = 0;
  int stall_left = 0;
  bit no_idle = 1'b0;
  bit hold_request = 1'b0;

  always #5 clk = ~clk;

  cubic_bezier_point_eval #(
    .COORD_WIDTH (COORD_WIDTH),
    .T_FRAC_BITS (T_FRAC_BITS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  cubic_bezier_point_eval_checker #(
    .COORD_WIDTH (COORD_WIDTH),
    .T_FRAC_BITS (T_FRAC_BITS)
  ) i_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .fault_count   (fault_count),
    .pending_count (pending_count),
    .checked_count (checked_count)
  );

  // Idle stretch length: mostly short, now and then a long one.
  function automatic int idle_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [P_WIDTH-1:0] pack_point(input logic signed [COORD_WIDTH-1:0] x,
                                                    input logic signed [COORD_WIDTH-1:0] y,
                                                    input logic signed [COORD_WIDTH-1:0] z);
    return {z, y, x};
  endfunction

  // Coordinates lean towards the extremes, where the blend is most likely to overflow.
  function automatic logic signed [COORD_WIDTH-1:0] random_coord();
    case ($urandom_range(0, 3))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      default: return COORD_WIDTH'($urandom);
    endcase
  endfunction

  function automatic logic [P_WIDTH-1:0] random_point();
    return pack_point(random_coord(), random_coord(), random_coord());
  endfunction

  // Parameter values: mostly inside the unit range, some around both clamp edges
  // and some over the whole field, negative ones included.
  function automatic logic [T_WIDTH-1:0] random_t();
    case ($urandom_range(0, 9))
      0:       return T_WIDTH'($urandom);
      1:       return T_UNIT + T_WIDTH'($urandom_range(0, 8)) - T_WIDTH'(4);
      2:       return T_WIDTH'($urandom_range(0, 8)) - T_WIDTH'(4);
      default: return T_WIDTH'($urandom_range(0, T_UNIT));
    endcase
  endfunction

  // Offers one parameter value, after a random gap, and waits for it to be taken.
  task automatic send_param(input logic [T_WIDTH-1:0] t);
    int gap;
    gap = (!no_idle && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= S_WIDTH'(t);
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // Stops offering and waits until every curve point has come back.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] index,
                           input logic [P_WIDTH-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
  endtask

  // Loads all four control points once the block is idle, then writes an
  // unused index, which must leave every point as it is.
  task automatic load_points(input logic [P_WIDTH-1:0] p0, input logic [P_WIDTH-1:0] p1,
                             input logic [P_WIDTH-1:0] p2, input logic [P_WIDTH-1:0] p3);
    wait_idle();
    write_reg(CFG_POINT_ZERO, p0);
    write_reg(CFG_POINT_ONE, p1);
    write_reg(CFG_POINT_TWO, p2);
    write_reg(CFG_POINT_THREE, p3);
    write_reg(CFG_INDEX_WIDTH'($urandom_range(CFG_POINT_THREE + 1, (1 << CFG_INDEX_WIDTH) - 1)),
              P_WIDTH'({$urandom, $urandom}));
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  // Receiver: random stalls, no stalls while idling is off, and one long
  // hold-off on request so that the pipeline fills and stalls its input.
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
        m_tready <= 1'b1;
      end else if (no_idle || stall_left == 0) begin
        m_tready <= 1'b1;
        if (!no_idle && $urandom_range(0, 3) == 0) stall_left = idle_len();
      end else begin
        m_tready <= 1'b0;
        stall_left--;
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // After reset every control point sits at the origin.
    send_param(T_HALF);
    send_param(T_MOST);

    // At the midpoint these coordinates land exactly on halves, which round upwards.
    load_points(pack_point(COORD_WIDTH'(4), COORD_WIDTH'(-4), COORD_WIDTH'(12)), '0, '0, '0);
    send_param(T_HALF);

    // Alternating extremes, swept over the corners of t and both clamps.
    load_points(pack_point(COORD_MAX, COORD_MAX, COORD_MIN),
                pack_point(COORD_MIN, COORD_MIN, COORD_MAX),
                pack_point(COORD_MAX, COORD_MIN, COORD_MAX),
                pack_point(COORD_MIN, COORD_MAX, COORD_MIN));
    foreach (T_CORNERS[i]) begin
      send_param(T_CORNERS[i]);
    end

    // Every coordinate at the top, then at the bottom of its range.
    load_points({3{COORD_MAX}}, {3{COORD_MAX}}, {3{COORD_MAX}}, {3{COORD_MAX}});
    send_param(T_HALF);
    send_param(T_UNIT - T_ONE_LSB);
    load_points({3{COORD_MIN}}, {3{COORD_MIN}}, {3{COORD_MIN}}, {3{COORD_MIN}});
    send_param(T_HALF);
    send_param(T_UNIT - T_ONE_LSB);

    // Random control points and parameter values.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      load_points(random_point(), random_point(), random_point(), random_point());
      if (phase == 1) begin
        // Back-to-back items against a long receiver hold-off.
        no_idle = 1'b1;
        hold_request = 1'b1;
        repeat (BURST_ITEMS) send_param(random_t());
        no_idle = 1'b0;
      end
      if (phase == 2) no_idle = 1'b1;
      repeat (PHASE_ITEMS) send_param(random_t());
      no_idle = 1'b0;
    end

    wait_idle();
    repeat (DRAIN) @(posedge clk);
    $display("Evaluated %0d parameter values under %0d control point settings;", items_sent,
             settings_loaded);
    $display("%0d curve points compared, with stalls and idle gaps on both streams.",
             checked_count);
    if (fault_count == 0) begin
      $display("PASS cubic_bezier_point_eval");
    end else begin
      $display("FAIL cubic_bezier_point_eval");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #(TIME_LIMIT);
    $display("FAIL cubic_bezier_point_eval");
    $finish;
  end

endmodule

>>> filelist.f
design/bcpe_pkg.sv
design/bcpe_weights.sv
design/bcpe_blend.sv
design/cubic_bezier_point_eval.sv
design/bcpe_checker.sv
sim/cubic_bezier_point_eval_checker.sv
sim/cubic_bezier_point_eval_test.sv
